### hdl/pwl_silu_pkg.sv
`timescale 1ns / 1ps

package pwl_silu_pkg;

  // Number formats
  localparam int FRAC_BITS    = 16;
  localparam int DATA_W       = 32;
  localparam int REG_W        = 31;
  localparam int COUNT_W      = 13;

  // Knot table
  localparam int MAX_SEGMENTS = 1024;
  localparam int KNOT_DEPTH   = MAX_SEGMENTS + 1;
  localparam int ADDR_W       = $clog2(KNOT_DEPTH);
  localparam int SEG_W        = $clog2(MAX_SEGMENTS);

  // Scaled position u = (x + R) * step_scale
  localparam int POS_W        = DATA_W + REG_W;
  localparam int HI_W         = POS_W - 2 * FRAC_BITS;
  localparam int FRAC_W       = FRAC_BITS + 1;
  localparam int DIFF_W       = DATA_W + 1;
  localparam int PROD_W       = FRAC_W + 1 + DIFF_W;

  // Request kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd2;

  // Reset values
  localparam logic [REG_W-1:0]   RANGE_RESET = 31'd262144;
  localparam logic [REG_W-1:0]   SCALE_RESET = 31'd524288;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd64;

endpackage

### hdl/pwl_silu_if.sv
`timescale 1ns / 1ps

interface pwl_silu_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [pwl_silu_pkg::DATA_W-1:0] sample_value;
  logic [pwl_silu_pkg::COUNT_W-1:0]       knot_index;
  logic signed [pwl_silu_pkg::DATA_W-1:0] knot_value;

  modport source (output valid, mode, sample_value, knot_index, knot_value, input ready);
  modport sink (input valid, mode, sample_value, knot_index, knot_value, output ready);
endinterface

interface pwl_silu_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pwl_silu_pkg::DATA_W-1:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

### hdl/piecewise_linear_silu.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    mode, sample_value, knot_index, knot_value
// out_ch    source     valid/ready    result_value
// cfg       write      cfg_we         cfg_index, cfg_data
//
// Seven register stages from request to result; one request enters per cycle
// while a stage is empty or out_ch is ready. An evaluate request gives a
// result; a load request writes its knot in stage three and gives no result.
// Reset (synchronous, rst_n low) empties the pipeline and restores the
// registers; the knot table is not cleared. A stall on out_ch holds only
// the full stages, so bubbles close up; in_ch is ready while any is empty.

module piecewise_linear_silu (
  input  logic                                   clk,
  input  logic                                   rst_n,
  pwl_silu_in_if.sink                            in_ch,
  pwl_silu_out_if.source                         out_ch,
  input  logic                                   cfg_we,
  input  logic [pwl_silu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwl_silu_pkg::REG_W-1:0]         cfg_data
);

  localparam int DW  = pwl_silu_pkg::DATA_W;
  localparam int RW  = pwl_silu_pkg::REG_W;
  localparam int CW  = pwl_silu_pkg::COUNT_W;
  localparam int AW  = pwl_silu_pkg::ADDR_W;
  localparam int SW  = pwl_silu_pkg::SEG_W;
  localparam int PW  = pwl_silu_pkg::POS_W;
  localparam int HW  = pwl_silu_pkg::HI_W;
  localparam int FW  = pwl_silu_pkg::FRAC_W;
  localparam int FB  = pwl_silu_pkg::FRAC_BITS;
  localparam int XW  = pwl_silu_pkg::DIFF_W;
  localparam int MW  = pwl_silu_pkg::PROD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RW-1:0] range_limit_r;
  logic [RW-1:0] step_scale_r;
  logic [CW-1:0] segment_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r   <= pwl_silu_pkg::RANGE_RESET;
      step_scale_r    <= pwl_silu_pkg::SCALE_RESET;
      segment_count_r <= pwl_silu_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwl_silu_pkg::CFG_RANGE_LIMIT:   range_limit_r   <= cfg_data;
        pwl_silu_pkg::CFG_STEP_SCALE:    step_scale_r    <= cfg_data;
        pwl_silu_pkg::CFG_SEGMENT_COUNT: segment_count_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Last usable segment: a count of zero acts as one, a count above the
  // table size saturates to it.
  logic [SW-1:0] last_seg;
  always_comb begin
    if (segment_count_r == '0) begin
      last_seg = '0;
    end else if (segment_count_r > CW'(pwl_silu_pkg::MAX_SEGMENTS)) begin
      last_seg = SW'(pwl_silu_pkg::MAX_SEGMENTS - 1);
    end else begin
      last_seg = SW'(segment_count_r - CW'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage occupancy and advance chain: a stage takes new contents when it is
  // empty or when the next stage takes its contents.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !out_v_r || out_ch.ready;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready = rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request
  // ---------------------------------------------------------------------------
  logic                 mode1_r;
  logic signed [DW-1:0] x1_r;
  logic [CW-1:0]        kidx1_r;
  logic [DW-1:0]        kval1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1_r <= in_ch.mode;
      x1_r    <= in_ch.sample_value;
      kidx1_r <= in_ch.knot_index;
      kval1_r <= in_ch.knot_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: range check, asymptote and offset x + R
  // ---------------------------------------------------------------------------
  logic signed [DW:0] x_ext, r_ext;
  logic               asym_nxt;
  logic [DW-1:0]      ax_nxt;
  logic [DW:0]        sum_full;

  assign x_ext    = {x1_r[DW-1], x1_r};
  assign r_ext    = {2'b00, range_limit_r};
  assign asym_nxt = (x_ext > r_ext) || (x_ext < -r_ext);
  // ReLU asymptote: x when positive, else zero
  assign ax_nxt   = (x1_r > 0) ? x1_r : '0;
  assign sum_full = x_ext + r_ext;

  logic          mode2_r, asym2_r;
  logic [DW-1:0] ax2_r, sum2_r;
  logic [CW-1:0] kidx2_r;
  logic [DW-1:0] kval2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2_r <= mode1_r;
      asym2_r <= asym_nxt;
      ax2_r   <= ax_nxt;
      sum2_r  <= sum_full[DW-1:0];
      kidx2_r <= kidx1_r;
      kval2_r <= kval1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale into table position u = (x + R) * step_scale
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pos_nxt;
  assign pos_nxt = PW'(sum2_r) * PW'(step_scale_r);

  logic          mode3_r, asym3_r;
  logic [DW-1:0] ax3_r;
  logic [PW-1:0] pos3_r;
  logic [CW-1:0] kidx3_r;
  logic [DW-1:0] kval3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mode3_r <= mode2_r;
      asym3_r <= asym2_r;
      ax3_r   <= ax2_r;
      pos3_r  <= pos_nxt;
      kidx3_r <= kidx2_r;
      kval3_r <= kval2_r;
    end
  end

  // Split u into segment and fraction; cap the segment at the last one,
  // where the fraction becomes exactly one.
  logic [HW-1:0] seg_hi;
  logic          seg_over;
  logic [SW-1:0] seg_idx;
  logic [FW-1:0] frac_nxt;
  logic [AW-1:0] rd_addr0, rd_addr1;

  assign seg_hi   = pos3_r[PW-1 -: HW];
  assign seg_over = (|seg_hi[HW-1:SW]) || (seg_hi[SW-1:0] > last_seg);
  assign seg_idx  = seg_over ? last_seg : seg_hi[SW-1:0];
  assign frac_nxt = seg_over ? FW'(1) << FB : {1'b0, pos3_r[2*FB-1 -: FB]};
  assign rd_addr0 = AW'(seg_idx);
  assign rd_addr1 = rd_addr0 + AW'(1);

  // Knot table: load requests write as they leave stage 3, evaluate requests
  // read both neighbours there, so requests see the table in arrival order.
  logic [DW-1:0] knot_mem [pwl_silu_pkg::KNOT_DEPTH];
  logic          knot_we;
  logic [DW-1:0] y0_r, y1_r;

  assign knot_we = v3_r && rdy4 && (mode3_r == pwl_silu_pkg::MODE_LOAD)
                   && (kidx3_r <= CW'(pwl_silu_pkg::MAX_SEGMENTS));

  always_ff @(posedge clk) begin
    if (knot_we) begin
      knot_mem[kidx3_r[AW-1:0]] <= kval3_r;
    end
    if (rdy4) begin
      y0_r <= knot_mem[rd_addr0];
      y1_r <= knot_mem[rd_addr1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: knots registered; form the knot difference
  // ---------------------------------------------------------------------------
  logic          asym4_r;
  logic [DW-1:0] ax4_r;
  logic [FW-1:0] frac4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      asym4_r <= asym3_r;
      ax4_r   <= ax3_r;
      frac4_r <= frac_nxt;
    end
  end

  logic signed [XW-1:0] diff_nxt;
  assign diff_nxt = $signed({y1_r[DW-1], y1_r}) - $signed({y0_r[DW-1], y0_r});

  // ---------------------------------------------------------------------------
  // Stage 5: multiply fraction by difference
  // ---------------------------------------------------------------------------
  logic                 asym5_r;
  logic [DW-1:0]        ax5_r, y0_5_r;
  logic [FW-1:0]        frac5_r;
  logic signed [XW-1:0] diff5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      asym5_r <= asym4_r;
      ax5_r   <= ax4_r;
      y0_5_r  <= y0_r;
      frac5_r <= frac4_r;
      diff5_r <= diff_nxt;
    end
  end

  logic signed [MW-1:0] prod_nxt;
  assign prod_nxt = $signed({1'b0, frac5_r}) * diff5_r;

  // ---------------------------------------------------------------------------
  // Stage 6: add the floored product to the lower knot, pick the asymptote
  // ---------------------------------------------------------------------------
  logic                 asym6_r;
  logic [DW-1:0]        ax6_r, y0_6_r;
  logic signed [MW-1:0] prod6_r;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      asym6_r <= asym5_r;
      ax6_r   <= ax5_r;
      y0_6_r  <= y0_5_r;
      prod6_r <= prod_nxt;
    end
  end

  // Dropping the low fraction bits of a two's complement product floors it
  logic [DW-1:0] interp_nxt;
  assign interp_nxt = y0_6_r + prod6_r[FB +: DW];

  // ---------------------------------------------------------------------------
  // Stage 7: output register
  // ---------------------------------------------------------------------------
  logic [DW-1:0] out_val_r;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      out_val_r <= asym6_r ? ax6_r : interp_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_value = out_val_r;

  // Valid bits; load requests drop out after the table write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r && (mode3_r == pwl_silu_pkg::MODE_EVAL);
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) out_v_r <= v6_r;
    end
  end

endmodule

### tb/pwl_silu_checker.sv
`timescale 1ns / 1ps

module pwl_silu_checker
  import pwl_silu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pwl_silu_in_if               in_ch,
  pwl_silu_out_if              out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending_results
);

  logic signed [DATA_W-1:0] knot_mem [KNOT_DEPTH];
  logic [REG_W-1:0]         range_q;
  logic [REG_W-1:0]         scale_q;
  logic [COUNT_W-1:0]       count_q;
  logic signed [DATA_W-1:0] expected_results [$];

  // Interpolated SiLU for one sample under the current table and registers
  function automatic logic signed [DATA_W-1:0] silu_approx(input logic signed [DATA_W-1:0] x);
    longint     r;
    longint     xs;
    longint     lo;
    longint     hi;
    longint     prod;
    logic [63:0] n;
    logic [63:0] pos;
    logic [63:0] seg;
    logic [63:0] frac;
    r  = longint'(range_q);
    xs = longint'(x);
    if (xs > r || xs < -r) return (xs > 0) ? x : '0;
    if (count_q == 0) n = 1;
    else if (count_q > MAX_SEGMENTS) n = MAX_SEGMENTS;
    else n = 64'(count_q);
    pos  = 64'(xs + r) * 64'(scale_q);
    seg  = pos >> (2 * FRAC_BITS);
    frac = (pos >> FRAC_BITS) & ((64'd1 << FRAC_BITS) - 1);
    if (seg > n - 1) begin
      seg  = n - 1;
      frac = 64'd1 << FRAC_BITS;
    end
    lo   = longint'(knot_mem[seg]);
    hi   = longint'(knot_mem[seg + 1]);
    prod = longint'(frac) * (hi - lo);
    return DATA_W'(lo + (prod >>> FRAC_BITS));
  endfunction

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (!rst_n) begin
      range_q = RANGE_RESET;
      scale_q = SCALE_RESET;
      count_q = COUNT_RESET;
      expected_results.delete();
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      // retire before admitting, so a result never meets its own request
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %0d (0x%08h), nothing expected",
                   $time, out_ch.result_value, out_ch.result_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_value !== want) begin
            $display("%0t: result_value expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, want, want, out_ch.result_value, out_ch.result_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_EVAL)
          expected_results.push_back(silu_approx(in_ch.sample_value));
        else if (in_ch.knot_index <= MAX_SEGMENTS)
          knot_mem[in_ch.knot_index] = in_ch.knot_value;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LIMIT:   range_q = cfg_data;
          CFG_STEP_SCALE:    scale_q = cfg_data;
          CFG_SEGMENT_COUNT: count_q = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      pending_results <= expected_results.size();
    end
  end

endmodule

### tb/piecewise_linear_silu_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the piecewise-linear SiLU block. A checker beside
// the block watches both channels and the register port, works out every
// result itself and counts mismatches; this module only drives requests,
// register writes and the result-side stalls.

module piecewise_linear_silu_tb;
  import pwl_silu_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int RANDOM_REQUESTS = 850;
  localparam int NUM_PHASES      = 12;
  localparam int PHASE_REQUESTS  = RANDOM_REQUESTS / NUM_PHASES;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HEAVY_PCT       = 69;
  localparam int LIGHT_PCT       = 23;

  // index past the last register: the block must leave everything untouched
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [REG_W-1:0]     REG_MAX   = '1;

  // edge samples around the reset half width
  localparam int R0 = int'(RANGE_RESET);
  localparam int EDGE_SAMPLES [11] = '{-2147483647 - 1, 2147483647, -R0, R0, 0,
                                       R0 + 1, -R0 - 1, 1 - R0, R0 - 1, -1, 1};

  // segment counts per random phase: extremes, odd sizes and saturating ones
  localparam int PHASE_COUNTS [NUM_PHASES] = '{64, 2, 3, 8191, 16, 100,
                                               4096, 256, 5, 1024, 32, 1};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending_results;

  int                   gap_pct;
  int                   stall_pct;
  logic [REG_W-1:0]     cur_range;
  logic [COUNT_W-1:0]   cur_count;
  bit                   knot_loaded [KNOT_DEPTH];

  pwl_silu_in_if  in_ch ();
  pwl_silu_out_if out_ch ();

  piecewise_linear_silu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pwl_silu_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("piecewise_linear_silu verification failed");
    $finish;
  end

  // result side: stall at the rate of the current idle mode
  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
  end

  function automatic int seg_in_use(input logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_SEGMENTS) return MAX_SEGMENTS;
    return int'(count);
  endfunction

  // step scale that spreads count segments over [-r, +r]
  function automatic logic [REG_W-1:0] matched_scale(input logic [REG_W-1:0] r,
                                                    input logic [COUNT_W-1:0] count);
    longint s;
    if (r == 0) return 1;
    s = (longint'(count) << 31) / longint'(r);
    if (s < 1) s = 1;
    if (s > longint'(REG_MAX)) s = longint'(REG_MAX);
    return REG_W'(s);
  endfunction

  // knot values: mostly modest, sometimes anything at all
  function automatic logic signed [DATA_W-1:0] knot_pattern();
    if ($urandom_range(3, 0) == 0) return $urandom;
    return int'($urandom_range(1 << 20, 0)) - (1 << 19);
  endfunction

  // samples: mostly inside the table, the rest on its edges or anywhere
  function automatic logic signed [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] span;
    span = {1'b0, cur_range};
    case ($urandom_range(15, 0))
      0:       return $urandom;
      1:       return span + 1;
      2:       return -span - 1;
      3:       return span;
      4:       return -span;
      5:       return span - 1;
      6:       return 1 - span;
      7:       return '0;
      default: return $urandom_range(span << 1, 0) - span;
    endcase
  endfunction

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;         stall_pct = 0;         end
      IDLE_SENDER:   begin gap_pct = HEAVY_PCT; stall_pct = 0;         end
      IDLE_RECEIVER: begin gap_pct = 0;         stall_pct = HEAVY_PCT; end
      default:       begin gap_pct = LIGHT_PCT; stall_pct = LIGHT_PCT; end
    endcase
  endtask

  // Present one request and hold it until the block takes it. Called right
  // after the clock rises; returns once the block has accepted the request.
  task automatic send_request(input logic m, input logic signed [DATA_W-1:0] sample,
                              input logic [COUNT_W-1:0] k,
                              input logic signed [DATA_W-1:0] v);
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.sample_value <= sample;
    in_ch.knot_index   <= k;
    in_ch.knot_value   <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (m == MODE_LOAD && k < KNOT_DEPTH) knot_loaded[k] = 1'b1;
  endtask

  // the fields a request does not use carry noise, so every bit gets toggled
  task automatic load_knot(input logic [COUNT_W-1:0] k, input logic signed [DATA_W-1:0] v);
    send_request(MODE_LOAD, $urandom, k, v);
  endtask

  task automatic eval_sample(input logic signed [DATA_W-1:0] x);
    send_request(MODE_EVAL, x, $urandom, $urandom);
  endtask

  // Drop valid, wait until the checker expects nothing, then let the pipe
  // run dry: a trailing load has no result to wait for.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write any knot the coming evaluations could read and that is still unset
  task automatic fill_table();
    for (int k = 0; k <= seg_in_use(cur_count); k++)
      if (!knot_loaded[k]) load_knot(COUNT_W'(k), knot_pattern());
  endtask

  // Write all three registers on an idle block, then complete the table.
  // cfg_we stays high across the burst and drops once at its end.
  task automatic configure(input logic [REG_W-1:0] r, input logic [REG_W-1:0] s,
                           input logic [COUNT_W-1:0] count);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RANGE_LIMIT;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= CFG_STEP_SCALE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_SEGMENT_COUNT;
    cfg_data  <= REG_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_range = r;
    cur_count = count;
    fill_table();
  endtask

  task automatic random_requests(input int total);
    logic [COUNT_W-1:0] k;
    for (int i = 0; i < total; i++) begin
      // vary the idle mode in stretches within a phase
      if (i % 40 == 39) set_idle(idle_mode_e'($urandom_range(3, 0)));
      if ($urandom_range(99, 0) < 15) begin
        case ($urandom_range(9, 0))
          0:       k = $urandom;
          1, 2:    k = $urandom_range(MAX_SEGMENTS, 0);
          default: k = $urandom_range(seg_in_use(cur_count), 0);
        endcase
        load_knot(k, knot_pattern());
      end else begin
        eval_sample(pick_sample());
      end
      // now and then hold off until every result is back
      if ($urandom_range(199, 0) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [REG_W-1:0] r;
    logic [REG_W-1:0] s;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_LOAD;
    in_ch.sample_value = '0;
    in_ch.knot_index   = '0;
    in_ch.knot_value   = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_RANGE_LIMIT;
    cfg_data           = '0;
    rst_n              = 1'b0;
    gap_pct            = 0;
    stall_pct          = 0;
    cur_range          = RANGE_RESET;
    cur_count          = COUNT_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // a write past the last register must change nothing
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we    <= 1'b0;

    // Directed: reset registers, out-of-table and top knot loads, extreme
    // knots at both ends, then samples on and around the table edges
    load_knot('1, -1);
    load_knot(COUNT_W'(KNOT_DEPTH), 12345);
    load_knot(COUNT_W'(MAX_SEGMENTS), 2147483647);
    fill_table();
    load_knot(0, -2147483647 - 1);
    load_knot(1, 2147483647);
    load_knot(COUNT_W'(COUNT_RESET) - 1, 2147483647);
    load_knot(COUNT_W'(COUNT_RESET), -2147483647 - 1);
    foreach (EDGE_SAMPLES[i]) eval_sample(EDGE_SAMPLES[i]);

    // zero half width: only x = 0 reaches the table
    configure('0, 1, '0);
    eval_sample(0);
    eval_sample(1);
    eval_sample(-1);

    // oversized step scale with one segment: every sample lands on segment 0
    configure(1, REG_MAX, 1);
    eval_sample(-1);
    eval_sample(0);
    eval_sample(1);

    // random phases over a spread of register settings and idle modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        3:       r = REG_MAX;
        5:       r = $urandom_range(REG_MAX, 1);
        8:       r = 1;
        default: r = $urandom_range(1 << 21, 1 << 12);
      endcase
      case (p)
        3:       s = REG_MAX;
        6:       s = $urandom_range(REG_MAX, 1);
        default: s = matched_scale(r, COUNT_W'(PHASE_COUNTS[p]));
      endcase
      set_idle(idle_mode_e'(p % 4));
      configure(r, s, COUNT_W'(PHASE_COUNTS[p]));
      random_requests(PHASE_REQUESTS);
    end

    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("piecewise_linear_silu verification clean");
    end else begin
      $display("piecewise_linear_silu verification failed");
    end
    $finish;
  end

endmodule

### piecewise_linear_silu.f
hdl/pwl_silu_pkg.sv
hdl/pwl_silu_if.sv
hdl/piecewise_linear_silu.sv
tb/pwl_silu_checker.sv
tb/piecewise_linear_silu_tb.sv
